[rtl/grp_pkg.sv]
// Shared types and constants for the guillotine rectangle packer.
// Holds the free-rectangle record, the controller states and the sizing constants.
// No dependencies.
package grp_pkg;

    localparam int MAX_FREE = 64;
    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;
    localparam int IDX_W    = $clog2(MAX_FREE);
    localparam int CNT_W    = $clog2(MAX_FREE + 1);

    localparam logic       REG_ATLAS_WIDTH  = 1'b0;
    localparam logic       REG_ATLAS_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] RESET_DIM  = DIM_W'(1024);

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_rect;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SHIFT,
        ST_APPEND
    } t_state;

endpackage

[rtl/guillotine_rect_packer_core.sv]
// Guillotine rectangle packer top level: free-list memory and its controller. Uses grp_pkg.
// Operation: one free entry is checked per cycle from the newest; an exact fit below the
// newest entry is followed by ST_SHIFT steps that close the gap, a split by an ST_APPEND
// step, and the result strobe is registered from the last state.
// busy is low again in the cycle that presents the result; results cannot be stalled.
// Synchronous reset restores one 1024 x 1024 free rectangle; a register write, the new atlas.
module guillotine_rect_packer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [grp_pkg::DIM_W-1:0]   i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [grp_pkg::DIM_W-1:0]   i_req_width,
    input  logic [grp_pkg::DIM_W-1:0]   i_req_height,
    output logic                        o_done,
    output logic                        o_placed,
    output logic [grp_pkg::COORD_W-1:0] o_place_x,
    output logic [grp_pkg::COORD_W-1:0] o_place_y,
    output logic                        o_list_full,
    output logic [grp_pkg::CNT_W-1:0]   o_free_entries
);
    import grp_pkg::*;

    t_rect mem [MAX_FREE];

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [DIM_W-1:0]   r_rw, r_rh;
    logic [DIM_W-1:0]   r_atlas_w, r_atlas_h;
    logic               r_fresh;
    logic               r_rd_fresh;
    t_rect              r_rd_data;
    t_rect              r_app, n_app;
    logic               r_done, n_done;
    logic               r_placed, n_placed;
    logic               r_full, n_full;
    logic [COORD_W-1:0] r_px, n_px, r_py, n_py;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_rect              mem_wdata;
    logic [IDX_W-1:0]   rd_addr;
    t_rect              cur;
    logic               accept;
    logic               fit, w_eq, h_eq;
    logic [DIM_W-1:0]   cfg_val;

    assign accept  = start && (r_state == ST_IDLE);
    assign cfg_val = (i_cfg_wdata > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg_wdata;

    // Entry 0 reads as the whole atlas until it is first written after a restart.
    assign cur  = r_rd_fresh ? t_rect'{x: '0, y: '0, w: r_atlas_w, h: r_atlas_h} : r_rd_data;
    assign fit  = (r_rw <= cur.w) && (r_rh <= cur.h);
    assign w_eq = (r_rw == cur.w);
    assign h_eq = (r_rh == cur.h);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_rd_fresh <= r_fresh && (rd_addr == '0);
        r_app      <= n_app;
        r_px       <= n_px;
        r_py       <= n_py;
        r_placed   <= n_placed;
        r_full     <= n_full;
        r_idx      <= n_idx;
        if (accept) begin
            r_rw <= i_req_width;
            r_rh <= i_req_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CNT_W'(1);
            r_atlas_w <= RESET_DIM;
            r_atlas_h <= RESET_DIM;
            r_fresh   <= 1'b1;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_ATLAS_WIDTH) begin
                    r_atlas_w <= cfg_val;
                end else begin
                    r_atlas_h <= cfg_val;
                end
                r_count <= CNT_W'(1);
                r_fresh <= 1'b1;
            end else begin
                r_count <= n_count;
                if (mem_we && mem_waddr == '0) begin
                    r_fresh <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_app     = r_app;
        n_done    = 1'b0;
        n_placed  = r_placed;
        n_full    = r_full;
        n_px      = r_px;
        n_py      = r_py;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = cur;
        rd_addr   = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_placed = 1'b0;
                    n_full   = 1'b0;
                    n_px     = '0;
                    n_py     = '0;
                    if (r_count == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_idx   = IDX_W'(r_count - CNT_W'(1));
                        rd_addr = n_idx;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (fit) begin
                    n_px = cur.x[COORD_W-1:0];
                    n_py = cur.y[COORD_W-1:0];
                    if (w_eq && h_eq) begin
                        n_placed = 1'b1;
                        if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                            n_count = r_count - CNT_W'(1);
                            n_done  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            rd_addr = r_idx + IDX_W'(1);
                            n_state = ST_SHIFT;
                        end
                    end else if (w_eq) begin
                        n_placed    = 1'b1;
                        mem_we      = 1'b1;
                        mem_wdata.y = cur.y + r_rh;
                        mem_wdata.h = cur.h - r_rh;
                        n_done      = 1'b1;
                        n_state     = ST_IDLE;
                    end else if (h_eq) begin
                        n_placed    = 1'b1;
                        mem_we      = 1'b1;
                        mem_wdata.x = cur.x + r_rw;
                        mem_wdata.w = cur.w - r_rw;
                        n_done      = 1'b1;
                        n_state     = ST_IDLE;
                    end else if (r_count >= CNT_W'(MAX_FREE)) begin
                        n_px    = '0;
                        n_py    = '0;
                        n_full  = 1'b1;
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        // Shrink the chosen entry now, append the right-hand part next cycle.
                        n_placed    = 1'b1;
                        mem_we      = 1'b1;
                        mem_wdata.y = cur.y + r_rh;
                        mem_wdata.h = cur.h - r_rh;
                        n_app.x     = cur.x + r_rw;
                        n_app.y     = cur.y;
                        n_app.w     = cur.w - r_rw;
                        n_app.h     = r_rh;
                        n_state     = ST_APPEND;
                    end
                end else if (r_idx == '0) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx - IDX_W'(1);
                    rd_addr = n_idx;
                end
            end
            ST_SHIFT: begin
                // The entry above r_idx was read last cycle; move it down one place.
                mem_we    = 1'b1;
                mem_wdata = cur;
                if (CNT_W'(r_idx) + CNT_W'(2) == r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    rd_addr = r_idx + IDX_W'(2);
                    n_idx   = r_idx + IDX_W'(1);
                end
            end
            ST_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(r_count);
                mem_wdata = r_app;
                n_count   = r_count + CNT_W'(1);
                n_done    = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_placed       = r_placed;
    assign o_place_x      = r_px;
    assign o_place_y      = r_py;
    assign o_list_full    = r_full;
    assign o_free_entries = r_count;

endmodule

[tb/sv/tb_guillotine_rect_packer_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for guillotine_rect_packer_core: a queue-fed driver, a monitor and
// a free-list predictor that tracks every placement. Depends on grp_pkg and the core RTL.
module tb_guillotine_rect_packer_core;
    import grp_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_FROM    = 300;
    localparam int QUIET_TO      = 600;
    localparam int MAX_PRINTS    = 60;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_CONFIG,
        OP_DRAIN
    } stim_kind_e;

    typedef struct {
        stim_kind_e       kind;
        logic             reg_sel;
        logic [DIM_W-1:0] a;
        logic [DIM_W-1:0] b;
    } stim_op_t;

    typedef struct packed {
        logic               placed;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               list_full;
        logic [CNT_W-1:0]   count;
    } placement_t;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic               i_cfg_addr   = 1'b0;
    logic [DIM_W-1:0]   i_cfg_wdata  = '0;
    logic               start        = 1'b0;
    logic [DIM_W-1:0]   i_req_width  = '0;
    logic [DIM_W-1:0]   i_req_height = '0;
    logic               busy;
    logic               o_done;
    logic               o_placed;
    logic [COORD_W-1:0] o_place_x;
    logic [COORD_W-1:0] o_place_y;
    logic               o_list_full;
    logic [CNT_W-1:0]   o_free_entries;

    stim_op_t   pending_ops[$];
    placement_t expected_placements[$];

    t_rect            free_list[MAX_FREE];
    int               free_count;
    logic [DIM_W-1:0] atlas_w;
    logic [DIM_W-1:0] atlas_h;

    logic accept_seen    = 1'b0;
    int   settle_cnt     = 0;
    int   issued_cnt     = 0;
    int   mismatch_count = 0;

    guillotine_rect_packer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_req_width    (i_req_width),
        .i_req_height   (i_req_height),
        .o_done         (o_done),
        .o_placed       (o_placed),
        .o_place_x      (o_place_x),
        .o_place_y      (o_place_y),
        .o_list_full    (o_list_full),
        .o_free_entries (o_free_entries)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic log_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic void restart_free_list();
        for (int i = 0; i < MAX_FREE; i++) begin
            free_list[i] = '0;
        end
        free_list[0].w = atlas_w;
        free_list[0].h = atlas_h;
        free_count = 1;
    endfunction

    // Scans from the newest free rectangle to the oldest and takes the first that fits.
    function automatic placement_t pack_request(logic [DIM_W-1:0] rw, logic [DIM_W-1:0] rh);
        placement_t res;
        t_rect      hit;
        int         n;
        res = '0;
        n = free_count;
        for (int i = n - 1; i >= 0; i--) begin
            if (rw <= free_list[i].w && rh <= free_list[i].h) begin
                hit = free_list[i];
                res.placed = 1'b1;
                if (rw == hit.w && rh == hit.h) begin
                    for (int j = i; j + 1 < n; j++) begin
                        free_list[j] = free_list[j + 1];
                    end
                    free_list[n - 1] = '0;
                    free_count = n - 1;
                end else if (rw == hit.w) begin
                    free_list[i].y = hit.y + rh;
                    free_list[i].h = hit.h - rh;
                end else if (rh == hit.h) begin
                    free_list[i].x = hit.x + rw;
                    free_list[i].w = hit.w - rw;
                end else if (n >= MAX_FREE) begin
                    res.placed    = 1'b0;
                    res.list_full = 1'b1;
                end else begin
                    // The right-hand remainder becomes the newest entry.
                    free_list[n] = '{hit.x + rw, hit.y, hit.w - rw, rh};
                    free_list[i].y = hit.y + rh;
                    free_list[i].h = hit.h - rh;
                    free_count = n + 1;
                end
                if (res.placed) begin
                    res.x = hit.x[COORD_W-1:0];
                    res.y = hit.y[COORD_W-1:0];
                end
                break;
            end
        end
        res.count = CNT_W'(free_count);
        return res;
    endfunction

    // Monitor: checks results, follows register writes and predicts each accepted request.
    always @(posedge i_clk) begin : monitor_proc
        placement_t want;
        logic [DIM_W-1:0] dim;
        if (!i_rst_n) begin
            atlas_w = RESET_DIM;
            atlas_h = RESET_DIM;
            restart_free_list();
            expected_placements.delete();
            accept_seen <= 1'b0;
        end else begin
            if (o_done) begin
                if (expected_placements.size() == 0) begin
                    log_mismatch("result strobe with no request outstanding");
                end else begin
                    want = expected_placements.pop_front();
                    if (o_placed !== want.placed)
                        log_mismatch($sformatf("placed %b, want %b", o_placed, want.placed));
                    if (o_place_x !== want.x)
                        log_mismatch($sformatf("place_x %0d, want %0d", o_place_x, want.x));
                    if (o_place_y !== want.y)
                        log_mismatch($sformatf("place_y %0d, want %0d", o_place_y, want.y));
                    if (o_list_full !== want.list_full)
                        log_mismatch($sformatf("list_full %b, want %b",
                                               o_list_full, want.list_full));
                    if (o_free_entries !== want.count)
                        log_mismatch($sformatf("free_entries %0d, want %0d",
                                               o_free_entries, want.count));
                end
            end
            if (i_cfg_we) begin
                dim = (i_cfg_wdata > MAX_DIM) ? DIM_W'(MAX_DIM) : i_cfg_wdata;
                if (i_cfg_addr == REG_ATLAS_WIDTH) begin
                    atlas_w = dim;
                end else begin
                    atlas_h = dim;
                end
                restart_free_list();
            end
            accept_seen <= start && !busy;
            if (start && !busy) begin
                expected_placements.push_back(pack_request(i_req_width, i_req_height));
            end
        end
    end

    // Driver: presents one operation at a time from the pending queue.
    always @(negedge i_clk) begin : driver_proc
        logic             nxt_start;
        logic             nxt_we;
        logic             nxt_sel;
        logic [DIM_W-1:0] nxt_data;
        logic [DIM_W-1:0] nxt_w;
        logic [DIM_W-1:0] nxt_h;
        logic             may_idle;
        stim_op_t         op;
        nxt_start = start;
        nxt_we    = 1'b0;
        nxt_sel   = i_cfg_addr;
        nxt_data  = i_cfg_wdata;
        nxt_w     = i_req_width;
        nxt_h     = i_req_height;
        if (i_rst_n) begin
            if (start && accept_seen) begin
                nxt_start = 1'b0;
            end
            if (!nxt_start && pending_ops.size() != 0) begin
                op = pending_ops[0];
                may_idle = !(issued_cnt >= QUIET_FROM && issued_cnt < QUIET_TO);
                if (op.kind == OP_REQUEST) begin
                    if (!(may_idle && $urandom_range(99) < 6)) begin
                        nxt_start = 1'b1;
                        nxt_w     = op.a;
                        nxt_h     = op.b;
                        void'(pending_ops.pop_front());
                        issued_cnt++;
                    end
                end else if (expected_placements.size() == 0 && !busy && !start) begin
                    // Register writes and drains wait until the core has gone quiet.
                    if (settle_cnt < SETTLE_CYCLES) begin
                        settle_cnt++;
                    end else begin
                        settle_cnt = 0;
                        if (op.kind == OP_CONFIG) begin
                            nxt_we   = 1'b1;
                            nxt_sel  = op.reg_sel;
                            nxt_data = op.a;
                        end
                        void'(pending_ops.pop_front());
                    end
                end else begin
                    settle_cnt = 0;
                end
            end
        end
        start        <= nxt_start;
        i_cfg_we     <= nxt_we;
        i_cfg_addr   <= nxt_sel;
        i_cfg_wdata  <= nxt_data;
        i_req_width  <= nxt_w;
        i_req_height <= nxt_h;
    end

    task automatic push_request(input int w, input int h);
        pending_ops.push_back('{OP_REQUEST, 1'b0, DIM_W'(w), DIM_W'(h)});
    endtask

    task automatic push_config(input logic sel, input int value);
        pending_ops.push_back('{OP_CONFIG, sel, DIM_W'(value), '0});
    endtask

    task automatic push_drain();
        pending_ops.push_back('{OP_DRAIN, 1'b0, '0, '0});
    endtask

    initial begin : stimulus_proc
        int rand_items;
        int mode;
        int aw;
        int ah;
        int n;
        int drain_at;
        rand_items = 0;

        // Reset list of 1024 x 1024: zero-sized split, exact fits, both shrinks, empty list.
        push_request(0, 0);
        push_request(1024, 0);
        push_request(1024, 100);
        push_request(100, 924);
        push_request(924, 924);
        push_request(1, 1);
        push_request(0, 0);
        // Oversized register values saturate to the largest atlas.
        push_config(REG_ATLAS_WIDTH, 8191);
        push_config(REG_ATLAS_HEIGHT, 4097);
        push_request(8191, 8191);
        push_request(4096, 4096);
        push_request(0, 0);
        // An empty atlas still holds one zero-sized free rectangle.
        push_config(REG_ATLAS_WIDTH, 0);
        push_config(REG_ATLAS_HEIGHT, 0);
        push_request(1, 0);
        push_request(0, 0);
        push_request(0, 0);
        push_config(REG_ATLAS_WIDTH, 1);
        push_config(REG_ATLAS_HEIGHT, 4096);
        push_request(1, 4095);
        push_request(1, 1);
        push_drain();

        // Growing heights force a split every time until the list is full; a width-matching
        // request then shrinks the newest entry in place, and the last request finds it full again.
        push_config(REG_ATLAS_WIDTH, 4096);
        push_config(REG_ATLAS_HEIGHT, 4096);
        for (int k = 1; k <= 64; k++) begin
            push_request(1, k);
        end
        push_request(1, 64);
        push_request(4095, 1);
        push_request(1, 64);
        rand_items += 67;

        while (rand_items < 1150) begin
            mode = $urandom_range(9);
            if (mode < 4) begin
                // Small coarse atlas: exact fits and an emptied list are frequent.
                aw = 4 * $urandom_range(1, 16);
                ah = 4 * $urandom_range(1, 16);
                n  = 40;
            end else if (mode < 7) begin
                aw = $urandom_range(1, 4) == 1 ? 4096 : $urandom_range(256, 4096);
                ah = 4096;
                n  = 100;
            end else if (mode < 9) begin
                aw = $urandom_range(0, 8191);
                ah = $urandom_range(0, 8191);
                n  = 30;
            end else begin
                aw = $urandom_range(1, 2) == 1 ? 0 : 8191;
                ah = $urandom_range(1, 2) == 1 ? 4096 : 1;
                n  = 10;
            end
            if ($urandom_range(1, 5) == 1) begin
                push_config($urandom_range(0, 1) ? REG_ATLAS_WIDTH : REG_ATLAS_HEIGHT,
                            $urandom_range(0, 1) ? aw : ah);
            end else if ($urandom_range(0, 1)) begin
                push_config(REG_ATLAS_WIDTH, aw);
                push_config(REG_ATLAS_HEIGHT, ah);
            end else begin
                push_config(REG_ATLAS_HEIGHT, ah);
                push_config(REG_ATLAS_WIDTH, aw);
            end
            drain_at = ($urandom_range(1, 4) == 1) ? $urandom_range(0, n - 1) : -1;
            for (int k = 0; k < n; k++) begin
                if (k == drain_at) begin
                    push_drain();
                end
                if (mode < 4) begin
                    push_request(4 * $urandom_range(0, 8), 4 * $urandom_range(0, 8));
                end else if (mode < 7) begin
                    if ($urandom_range(1, 10) == 1) begin
                        push_request($urandom_range(0, 8191), $urandom_range(0, 8191));
                    end else begin
                        push_request($urandom_range(0, 64), $urandom_range(0, 150));
                    end
                end else begin
                    push_request($urandom_range(0, 8191), $urandom_range(0, 8191));
                end
            end
            rand_items += n;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || start) @(posedge i_clk);
        while (expected_placements.size() != 0) @(posedge i_clk);
        repeat (2 * MAX_FREE + 8) @(posedge i_clk);
        if (expected_placements.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", expected_placements.size()));
        end
        if (mismatch_count == 0) begin
            $display("tb_guillotine_rect_packer_core passed");
        end else begin
            $display("tb_guillotine_rect_packer_core failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #10_000_000;
        $display("tb_guillotine_rect_packer_core failed");
        $finish;
    end

endmodule
